// ===== rtl/bgabd_pkg.sv =====
// Shared types and constants of the board gate array bus decoder.
// Used by bgabd_decode, bgabd_state and board_gate_array_bus_decoder.
`default_nettype none

package bgabd_pkg;

	// Display queue depth default
	localparam int unsigned DISPLAY_QUEUE_DEPTH_DEF = 256;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TYPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANKS  = 1'd1;

	// Bank numbers and ROM bank limits
	localparam logic [7:0] BANK_LOW_RAM    = 8'h10;
	localparam logic [7:0] BANK_HIGH_RAM   = 8'h11;
	localparam logic [3:0] ROM_BANKS_MAX   = 4'd8;
	localparam logic [3:0] ROM_BANKS_RESET = 4'd4;

	// Access kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef enum logic [2:0] {
		TGT_INTERNAL    = 3'd0,
		TGT_SOUND       = 3'd1,
		TGT_ROM         = 3'd2,
		TGT_LOW_RAM     = 3'd3,
		TGT_HIGH_RAM    = 3'd4,
		TGT_DISP_DATA   = 3'd5,
		TGT_DISP_STROBE = 3'd6
	} target_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  switch_group_a;
		logic [7:0]  switch_group_b;
	} item_t;

	typedef struct packed {
		logic       board_type;
		logic [3:0] rom_banks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] bank;
		logic [7:0] latch;
		logic [7:0] rtime;
		logic [7:0] rlevel;
	} regs_t;

	typedef struct packed {
		logic [7:0]  read_data;
		target_t     target;
		logic [16:0] target_offset;
		logic        code_write_hit;
		logic [7:0]  window_bank;
		logic        message_lamp;
		logic        reverb_update;
		logic [2:0]  reverb_program;
		logic [2:0]  reverb_time;
		logic [2:0]  reverb_level;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/bgabd_decode.sv =====
// Combinational address decode of one bus access: result word and next register values.
// Depends on bgabd_pkg.
`default_nettype none

module bgabd_decode #(
	parameter int unsigned DisplayQueueDepth = bgabd_pkg::DISPLAY_QUEUE_DEPTH_DEF
) (
	input  bgabd_pkg::item_t                           item,
	input  bgabd_pkg::cfg_t                            cfg,
	input  bgabd_pkg::regs_t                           regs,
	input  logic [$clog2(DisplayQueueDepth+1)-1:0]     count,
	output bgabd_pkg::result_t                         result,
	output bgabd_pkg::regs_t                           regs_next,
	output logic [$clog2(DisplayQueueDepth+1)-1:0]     count_next
);
	import bgabd_pkg::*;

	localparam int unsigned CntW = $clog2(DisplayQueueDepth + 1);

	logic [15:0] a;
	logic [3:0]  banks;
	logic        snd_hit;
	logic [8:0]  snd_reg;
	logic        win_hit;
	logic        in_switch, in_bank, in_ignore, in_disp, in_strobe;
	logic [7:0]  sw;
	logic [2:0]  t, l;
	logic [1:0]  m;

	assign a = item.address;

	// Clamp the ROM bank count
	assign banks = (cfg.rom_banks > ROM_BANKS_MAX) ? ROM_BANKS_MAX : cfg.rom_banks;

	// Page decode in 128-byte blocks
	assign in_bank   = (a[15:7] == 9'h002);
	assign in_switch = (a[15:7] == 9'h004);
	assign in_ignore = (a[15:7] == 9'h005);
	assign in_disp   = (a[15:7] == 9'h006);
	assign in_strobe = (a[15:7] == 9'h007);
	assign win_hit   = (a[15:14] == 2'b10);

	// Sound chip window: pair-wide on the old board
	always_comb begin
		if (cfg.board_type) begin
			snd_hit = (a[15:10] == 6'b000011);
			snd_reg = a[9:1];
		end else begin
			snd_hit = (a[15:9] == 7'b0000110);
			snd_reg = a[8:0];
		end
	end

	// Switch matrix read
	always_comb begin
		sw = 8'hff;
		if (!a[2]) sw = sw & item.switch_group_a;
		if (!a[1]) sw = sw & item.switch_group_b;
	end

	// Decode the access, then repack reverb bits from the updated registers
	always_comb begin
		regs_next             = regs;
		count_next            = count;
		result.read_data      = (item.kind == KIND_WRITE) ? 8'h00 : 8'hff;
		result.target         = TGT_INTERNAL;
		result.target_offset  = '0;
		result.code_write_hit = 1'b0;
		result.reverb_update  = 1'b0;
		if (item.kind == KIND_READ) begin
			if (in_switch) begin
				result.read_data = sw;
			end else if (in_strobe) begin
				result.read_data = 8'h00;
			end else if (snd_hit) begin
				result.target        = TGT_SOUND;
				result.target_offset = 17'(snd_reg);
			end else if (win_hit) begin
				if (regs.bank < {4'd0, banks}) begin
					result.target        = TGT_ROM;
					result.target_offset = {regs.bank[2:0], a[13:0]};
				end else if (regs.bank == BANK_LOW_RAM) begin
					result.target        = TGT_LOW_RAM;
					result.target_offset = 17'(a[13:0]);
				end else if (regs.bank == BANK_HIGH_RAM) begin
					result.target        = TGT_HIGH_RAM;
					result.target_offset = 17'(a[13:0]);
				end
			end
		end else begin
			if (in_bank) begin
				regs_next.bank = item.write_data;
			end else if (in_switch) begin
				regs_next.latch      = item.write_data;
				result.reverb_update = 1'b1;
			end else if (in_ignore) begin
				regs_next = regs;
			end else if (in_disp) begin
				// Queue the byte unless full; drop it otherwise
				if (count < CntW'(DisplayQueueDepth)) begin
					result.target        = TGT_DISP_DATA;
					result.target_offset = 17'(count);
					count_next           = count + CntW'(1);
				end
			end else if (in_strobe) begin
				result.target        = TGT_DISP_STROBE;
				result.target_offset = 17'(count);
				count_next           = '0;
			end else if (a == 16'h0400) begin
				regs_next.rtime      = item.write_data;
				result.reverb_update = 1'b1;
			end else if (a == 16'h0800) begin
				regs_next.rlevel     = item.write_data;
				result.reverb_update = 1'b1;
			end else if (snd_hit) begin
				result.target        = TGT_SOUND;
				result.target_offset = 17'(snd_reg);
			end else if (win_hit) begin
				if (regs.bank == BANK_LOW_RAM) begin
					result.target         = TGT_LOW_RAM;
					result.target_offset  = 17'(a[13:0]);
					result.code_write_hit = 1'b1;
				end else if (regs.bank == BANK_HIGH_RAM) begin
					result.target         = TGT_HIGH_RAM;
					result.target_offset  = 17'(a[13:0]);
					result.code_write_hit = 1'b1;
				end
			end
		end

		if (cfg.board_type) begin
			t = regs_next.rtime[3:1];
			l = {regs_next.rlevel[2:1], regs_next.rtime[4]};
			m = {regs_next.latch[2], regs_next.rlevel[3]};
		end else begin
			t = regs_next.rtime[2:0];
			l = {regs_next.rlevel[1:0], regs_next.rtime[3]};
			m = {regs_next.latch[1], regs_next.rlevel[2]};
		end

		result.window_bank    = regs_next.bank;
		result.message_lamp   = regs_next.latch[0];
		result.reverb_program = {1'b1, m};
		result.reverb_time    = t;
		result.reverb_level   = l;
	end

endmodule

`default_nettype wire

// ===== rtl/bgabd_state.sv =====
// Configuration registers and decoder state (bank, latch, reverb, display queue count).
// Depends on bgabd_pkg.
`default_nettype none

module bgabd_state #(
	parameter int unsigned DisplayQueueDepth = bgabd_pkg::DISPLAY_QUEUE_DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_write,
	input  logic [bgabd_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [bgabd_pkg::CFG_DATA_W-1:0]           cfg_data,
	input  logic                                       update,
	input  bgabd_pkg::regs_t                           regs_next,
	input  logic [$clog2(DisplayQueueDepth+1)-1:0]     count_next,
	output bgabd_pkg::cfg_t                            cfg,
	output bgabd_pkg::regs_t                           regs,
	output logic [$clog2(DisplayQueueDepth+1)-1:0]     count
);
	import bgabd_pkg::*;

	cfg_t  cfg_q;
	regs_t regs_q;
	logic [$clog2(DisplayQueueDepth+1)-1:0] count_q;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_type <= 1'b0;
			cfg_q.rom_banks  <= ROM_BANKS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BOARD_TYPE: cfg_q.board_type <= cfg_data[0];
				CFG_ROM_BANKS:  cfg_q.rom_banks  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance state as each word leaves the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q  <= '0;
			count_q <= '0;
		end else if (update) begin
			regs_q  <= regs_next;
			count_q <= count_next;
		end
	end

	assign cfg   = cfg_q;
	assign regs  = regs_q;
	assign count = count_q;

endmodule

`default_nettype wire

// ===== rtl/board_gate_array_bus_decoder.sv =====
// Top level of the board gate array bus decoder: input register, decode, result register.
// Depends on bgabd_pkg, bgabd_state and bgabd_decode.
//
//   channel  | signals                          | direction | word
//   in       | in_valid / in_ready              | in        | one bus access
//   out      | out_valid / out_ready            | out       | one decode result
//   cfg      | cfg_write, cfg_index, cfg_data   | in        | one register write
//
// One access is taken per cycle while the output is not stalled; its result word passes the
// input register, the single decode stage and the result register, which captures it once
// the result slot is free.
// Reset clears valid flags, bank, latch, reverb registers and the display count;
// rom_banks returns to 4 and board_type to 0.
// A stalled output holds its word; the input register still drains into an empty result slot.
`default_nettype none

module board_gate_array_bus_decoder #(
	parameter int unsigned DisplayQueueDepth = bgabd_pkg::DISPLAY_QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bgabd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgabd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [15:0]                         address,
	input  logic [7:0]                          write_data,
	input  logic [7:0]                          switch_group_a,
	input  logic [7:0]                          switch_group_b,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          read_data,
	output logic [2:0]                          target,
	output logic [16:0]                         target_offset,
	output logic                                code_write_hit,
	output logic [7:0]                          window_bank,
	output logic                                message_lamp,
	output logic                                reverb_update,
	output logic [2:0]                          reverb_program,
	output logic [2:0]                          reverb_time,
	output logic [2:0]                          reverb_level
);
	import bgabd_pkg::*;

	localparam int unsigned CntW = $clog2(DisplayQueueDepth + 1);

	item_t     item_s1;
	logic      valid_s1;
	result_t   result_s2;
	logic      valid_s2;
	logic      adv_s1;
	cfg_t      cfg;
	regs_t     regs, regs_next;
	logic [CntW-1:0] count, count_next;
	result_t   result;

	// Move a word out of the decode stage when the result slot is free
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: kind, address: address, write_data: write_data,
				switch_group_a: switch_group_a, switch_group_b: switch_group_b};
		end
	end

	bgabd_state #(
		.DisplayQueueDepth(DisplayQueueDepth)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.update    (adv_s1),
		.regs_next (regs_next),
		.count_next(count_next),
		.cfg       (cfg),
		.regs      (regs),
		.count     (count)
	);

	bgabd_decode #(
		.DisplayQueueDepth(DisplayQueueDepth)
	) u_decode (
		.item      (item_s1),
		.cfg       (cfg),
		.regs      (regs),
		.count     (count),
		.result    (result),
		.regs_next (regs_next),
		.count_next(count_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign read_data      = result_s2.read_data;
	assign target         = result_s2.target;
	assign target_offset  = result_s2.target_offset;
	assign code_write_hit = result_s2.code_write_hit;
	assign window_bank    = result_s2.window_bank;
	assign message_lamp   = result_s2.message_lamp;
	assign reverb_update  = result_s2.reverb_update;
	assign reverb_program = result_s2.reverb_program;
	assign reverb_time    = result_s2.reverb_time;
	assign reverb_level   = result_s2.reverb_level;

	// Checks on the decode result
	a_internal_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_INTERNAL |-> target_offset == 17'd0)
		else $error("internal target with nonzero offset");

	a_code_in_ram: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_write_hit |-> (target == TGT_LOW_RAM || target == TGT_HIGH_RAM))
		else $error("code write outside banked RAM");

	a_reverb_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reverb_update |-> read_data == 8'h00 && target == TGT_INTERNAL)
		else $error("reverb update on a non-register access");

	a_strobe_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && result.target == TGT_DISP_STROBE |=> count == '0)
		else $error("display queue not emptied by strobe");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CntW'(DisplayQueueDepth))
		else $error("display queue count beyond depth");

endmodule

`default_nettype wire

// ===== dv/bgabd_decode_checker.sv =====
// Checker for the board gate array bus decoder: watches the access, result and
// register write ports, predicts each decode and compares it with the result word.
// Depends on bgabd_pkg for the word layouts, target codes and register indexes.
module bgabd_decode_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [bgabd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgabd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             kind,
	input  logic [15:0]                      address,
	input  logic [7:0]                       write_data,
	input  logic [7:0]                       switch_group_a,
	input  logic [7:0]                       switch_group_b,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [7:0]                       read_data,
	input  logic [2:0]                       target,
	input  logic [16:0]                      target_offset,
	input  logic                             code_write_hit,
	input  logic [7:0]                       window_bank,
	input  logic                             message_lamp,
	input  logic                             reverb_update,
	input  logic [2:0]                       reverb_program,
	input  logic [2:0]                       reverb_time,
	input  logic [2:0]                       reverb_level,
	output int                               errors,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bgabd_pkg::*;

	localparam int QUEUE_DEPTH = DISPLAY_QUEUE_DEPTH_DEF;

	// Shadow copy of the decoder registers and configuration
	logic       board_old;
	logic [3:0] rom_banks;
	logic [7:0] bank_sel;
	logic [7:0] latch;
	logic [7:0] rtime;
	logic [7:0] rlevel;
	logic [8:0] disp_count;

	result_t decode_q[$];
	result_t want;
	result_t predicted;
	item_t   access_word;

	assign access_word = {kind, address, write_data, switch_group_a, switch_group_b};

	// Decode one access against the shadow state and advance that state
	task automatic decode_access(input item_t w, output result_t r);
		logic [3:0]  banks;
		logic        chip_hit;
		logic [16:0] chip_idx;
		logic [15:0] a;
		logic [7:0]  sw;
		a = w.address;
		banks = (rom_banks > ROM_BANKS_MAX) ? ROM_BANKS_MAX : rom_banks;

		// sound chip window: pair-wide on the old board, byte-wide on the new one
		chip_hit = 1'b0;
		chip_idx = '0;
		if (board_old) begin
			if (a >= 16'h0c00 && a < 16'h1000) begin
				chip_hit = 1'b1;
				chip_idx = {1'b0, a - 16'h0c00} >> 1;
			end
		end else if (a >= 16'h0c00 && a < 16'h0e00) begin
			chip_hit = 1'b1;
			chip_idx = {1'b0, a - 16'h0c00};
		end

		r = '0;
		r.target = TGT_INTERNAL;
		r.read_data = (w.kind == KIND_WRITE) ? 8'h00 : 8'hff;

		if (w.kind == KIND_READ) begin
			if (a >= 16'h0200 && a <= 16'h027f) begin
				// switch matrix: a clear select bit gates its group in
				sw = 8'hff;
				if (!a[2]) sw = sw & w.switch_group_a;
				if (!a[1]) sw = sw & w.switch_group_b;
				r.read_data = sw;
			end else if (a >= 16'h0380 && a <= 16'h03ff) begin
				r.read_data = 8'h00;
			end else if (chip_hit) begin
				r.target = TGT_SOUND;
				r.target_offset = chip_idx;
			end else if (a[15:14] == 2'b10) begin
				if (bank_sel < {4'd0, banks}) begin
					r.target = TGT_ROM;
					r.target_offset = {bank_sel[2:0], a[13:0]};
				end else if (bank_sel == BANK_LOW_RAM) begin
					r.target = TGT_LOW_RAM;
					r.target_offset = {3'd0, a[13:0]};
				end else if (bank_sel == BANK_HIGH_RAM) begin
					r.target = TGT_HIGH_RAM;
					r.target_offset = {3'd0, a[13:0]};
				end
			end
		end else begin
			if (a >= 16'h0100 && a <= 16'h017f) begin
				bank_sel = w.write_data;
			end else if (a >= 16'h0200 && a <= 16'h027f) begin
				latch = w.write_data;
				r.reverb_update = 1'b1;
			end else if (a >= 16'h0280 && a <= 16'h02ff) begin
				// dead range, drop the write
			end else if (a >= 16'h0300 && a <= 16'h037f) begin
				// queue a display byte unless the queue is full
				if (disp_count < QUEUE_DEPTH) begin
					r.target = TGT_DISP_DATA;
					r.target_offset = {8'd0, disp_count};
					disp_count = disp_count + 9'd1;
				end
			end else if (a >= 16'h0380 && a <= 16'h03ff) begin
				r.target = TGT_DISP_STROBE;
				r.target_offset = {8'd0, disp_count};
				disp_count = '0;
			end else if (a == 16'h0400) begin
				rtime = w.write_data;
				r.reverb_update = 1'b1;
			end else if (a == 16'h0800) begin
				rlevel = w.write_data;
				r.reverb_update = 1'b1;
			end else if (chip_hit) begin
				r.target = TGT_SOUND;
				r.target_offset = chip_idx;
			end else if (a[15:14] == 2'b10) begin
				if (bank_sel == BANK_LOW_RAM) begin
					r.target = TGT_LOW_RAM;
					r.target_offset = {3'd0, a[13:0]};
					r.code_write_hit = 1'b1;
				end else if (bank_sel == BANK_HIGH_RAM) begin
					r.target = TGT_HIGH_RAM;
					r.target_offset = {3'd0, a[13:0]};
					r.code_write_hit = 1'b1;
				end
			end
		end

		r.window_bank = bank_sel;
		r.message_lamp = latch[0];

		// repack reverb bits; the old board has them one place higher
		if (board_old) begin
			r.reverb_time = rtime[3:1];
			r.reverb_level = {rlevel[2:1], rtime[4]};
			r.reverb_program = {1'b1, latch[2], rlevel[3]};
		end else begin
			r.reverb_time = rtime[2:0];
			r.reverb_level = {rlevel[1:0], rtime[3]};
			r.reverb_program = {1'b1, latch[1], rlevel[2]};
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_val,
		input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			errors++;
		end
	endtask

	// Apply register writes, retire result words, then take the new access word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_old = 1'b0;
			rom_banks = ROM_BANKS_RESET;
			bank_sel = '0;
			latch = '0;
			rtime = '0;
			rlevel = '0;
			disp_count = '0;
			decode_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_BOARD_TYPE) board_old = cfg_data[0];
				else if (cfg_index == CFG_ROM_BANKS) rom_banks = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (decode_q.size() == 0) begin
					$error("result word with no access outstanding");
					errors++;
				end else begin
					want = decode_q.pop_front();
					check_field("read_data", want.read_data, read_data);
					check_field("target", want.target, target);
					check_field("target_offset", want.target_offset, target_offset);
					check_field("code_write_hit", want.code_write_hit, code_write_hit);
					check_field("window_bank", want.window_bank, window_bank);
					check_field("message_lamp", want.message_lamp, message_lamp);
					check_field("reverb_update", want.reverb_update, reverb_update);
					check_field("reverb_program", want.reverb_program, reverb_program);
					check_field("reverb_time", want.reverb_time, reverb_time);
					check_field("reverb_level", want.reverb_level, reverb_level);
				end
			end
			if (in_valid && in_ready) begin
				decode_access(access_word, predicted);
				decode_q.insert(decode_q.size(), predicted);
			end
			outstanding = decode_q.size();
		end
	end

endmodule

// ===== dv/board_gate_array_bus_decoder_test.sv =====
// Testbench top for the board gate array bus decoder: clock, reset, access words,
// register writes and the verdict. Checking lives in bgabd_decode_checker.
// Depends on bgabd_pkg, bgabd_decode_checker and the decoder RTL.
module board_gate_array_bus_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bgabd_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  kind;
	logic [15:0]           address;
	logic [7:0]            write_data;
	logic [7:0]            switch_group_a;
	logic [7:0]            switch_group_b;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            read_data;
	logic [2:0]            target;
	logic [16:0]           target_offset;
	logic                  code_write_hit;
	logic [7:0]            window_bank;
	logic                  message_lamp;
	logic                  reverb_update;
	logic [2:0]            reverb_program;
	logic [2:0]            reverb_time;
	logic [2:0]            reverb_level;

	int fail_count;
	int words_outstanding;
	int words_sent;
	bit calm;

	board_gate_array_bus_decoder u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .address(address), .write_data(write_data),
		.switch_group_a(switch_group_a), .switch_group_b(switch_group_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .target(target), .target_offset(target_offset),
		.code_write_hit(code_write_hit), .window_bank(window_bank),
		.message_lamp(message_lamp), .reverb_update(reverb_update),
		.reverb_program(reverb_program), .reverb_time(reverb_time),
		.reverb_level(reverb_level)
	);

	bgabd_decode_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .address(address), .write_data(write_data),
		.switch_group_a(switch_group_a), .switch_group_b(switch_group_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .target(target), .target_offset(target_offset),
		.code_write_hit(code_write_hit), .window_bank(window_bank),
		.message_lamp(message_lamp), .reverb_update(reverb_update),
		.reverb_program(reverb_program), .reverb_time(reverb_time),
		.reverb_level(reverb_level),
		.errors(fail_count), .outstanding(words_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the handshake hangs
	initial begin
		#2000000;
		$display("board_gate_array_bus_decoder regression: fail");
		$finish;
	end

	// Result side: stall now and then, never during the calm stretch
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = calm || ($urandom_range(99) >= 6);
		end
	end

	// Present one access word and hold it until it is taken
	task automatic send_word(input logic k, input logic [15:0] a, input logic [7:0] d,
		input logic [7:0] ga, input logic [7:0] gb);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 6) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		address = a;
		write_data = d;
		switch_group_a = ga;
		switch_group_b = gb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// Drop valid and hold off until every result word is back
	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		wait (words_outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	initial begin
		int bank_list [5];
		int p;
		int n;
		int sel;
		int phase_end;
		logic k;
		logic [15:0] a;
		logic [7:0] d;

		bank_list = '{0, 8, 15, 1, 8};
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_READ;
		address = '0;
		write_data = '0;
		switch_group_a = '0;
		switch_group_b = '0;
		calm = 1'b0;
		words_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words at reset configuration: switch selects and status reads
		send_word(KIND_READ, 16'h0200, 8'h00, 8'h00, 8'hff);
		send_word(KIND_READ, 16'h0202, 8'h00, 8'ha5, 8'h5a);
		send_word(KIND_READ, 16'h0204, 8'h00, 8'h5a, 8'ha5);
		send_word(KIND_READ, 16'h027f, 8'h00, 8'h00, 8'h00);
		send_word(KIND_READ, 16'h0380, 8'h00, 8'hff, 8'hff);
		send_word(KIND_READ, 16'h0000, 8'h00, 8'hff, 8'hff);
		send_word(KIND_READ, 16'hffff, 8'hff, 8'h00, 8'h00);
		// latch, reverb registers and the dead range
		send_word(KIND_WRITE, 16'h0200, 8'hff, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h0400, 8'hff, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h0800, 8'hff, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h02ff, 8'h00, 8'hff, 8'hff);
		// display bytes, a strobe and a read of the data range
		send_word(KIND_WRITE, 16'h0300, 8'h41, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h037f, 8'hff, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h03ff, 8'h80, 8'h00, 8'h00);
		send_word(KIND_READ, 16'h0300, 8'h00, 8'h00, 8'h00);
		// sound chip edges
		send_word(KIND_READ, 16'h0c00, 8'h00, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h0dff, 8'h55, 8'h00, 8'h00);
		send_word(KIND_READ, 16'h0e00, 8'h00, 8'h00, 8'h00);
		// bank window: ROM, both RAM banks, absent bank
		send_word(KIND_WRITE, 16'h0100, 8'h03, 8'h00, 8'h00);
		send_word(KIND_READ, 16'hbfff, 8'h00, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h017f, BANK_LOW_RAM, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h8000, 8'hc3, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h0100, BANK_HIGH_RAM, 8'h00, 8'h00);
		send_word(KIND_READ, 16'hbfff, 8'h00, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h0100, 8'h04, 8'h00, 8'h00);
		send_word(KIND_READ, 16'h8000, 8'h00, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h9000, 8'h12, 8'h00, 8'h00);
		send_word(KIND_WRITE, 16'h0100, 8'hff, 8'h00, 8'h00);

		// Random phases, one register setting each
		for (p = 0; p < 5; p++) begin
			drain();
			write_reg(CFG_BOARD_TYPE, (p % 2 == 0) ? 4'd1 : 4'd0);
			write_reg(CFG_ROM_BANKS, bank_list[p][3:0]);
			calm = (p == 2);
			phase_end = words_sent + 290;

			// overfill the display queue once, then strobe
			if (p == 1) begin
				for (n = 0; n < 258; n++)
					send_word(KIND_WRITE, 16'h0300 + 16'($urandom_range(0, 16'h7f)),
						8'($urandom), 8'($urandom), 8'($urandom));
				send_word(KIND_WRITE, 16'h0380, 8'($urandom), 8'($urandom), 8'($urandom));
			end

			while (words_sent < phase_end) begin
				// occasional display burst of random length
				if ($urandom_range(99) == 0) begin
					n = $urandom_range(1, 270);
					repeat (n)
						send_word(KIND_WRITE, 16'h0300 + 16'($urandom_range(0, 16'h7f)),
							8'($urandom), 8'($urandom), 8'($urandom));
					send_word(KIND_WRITE, 16'h0380 + 16'($urandom_range(0, 16'h7f)),
						8'($urandom), 8'($urandom), 8'($urandom));
				end else begin
					sel = $urandom_range(99);
					k = 1'($urandom_range(1));
					d = 8'($urandom);
					if (sel < 10)
						a = 16'h0200 + 16'($urandom_range(0, 16'h7f));
					else if (sel < 15)
						a = 16'h0280 + 16'($urandom_range(0, 16'h7f));
					else if (sel < 25) begin
						a = 16'h0100 + 16'($urandom_range(0, 16'h7f));
						k = ($urandom_range(9) != 0) ? KIND_WRITE : KIND_READ;
						case ($urandom_range(3))
							0: d = 8'($urandom_range(0, 9));
							1: d = BANK_LOW_RAM;
							2: d = BANK_HIGH_RAM;
							default: d = 8'($urandom);
						endcase
					end else if (sel < 40)
						a = 16'h0300 + 16'($urandom_range(0, 16'h7f));
					else if (sel < 45)
						a = 16'h0380 + 16'($urandom_range(0, 16'h7f));
					else if (sel < 53)
						a = $urandom_range(1) ? 16'h0400 : 16'h0800;
					else if (sel < 65)
						a = 16'h0c00 + 16'($urandom_range(0, 16'h3ff));
					else if (sel < 85)
						a = 16'h8000 + 16'($urandom_range(0, 16'h3fff));
					else
						a = 16'($urandom);
					send_word(k, a, d, 8'($urandom), 8'($urandom));
				end
			end
			calm = 1'b0;
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && words_outstanding == 0)
			$display("board_gate_array_bus_decoder regression: pass");
		else
			$display("board_gate_array_bus_decoder regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bgabd_pkg.sv
rtl/bgabd_decode.sv
rtl/bgabd_state.sv
rtl/board_gate_array_bus_decoder.sv
dv/bgabd_decode_checker.sv
dv/board_gate_array_bus_decoder_test.sv
